// File: design/mps_pkg.sv
// ----------------------------------------------------------------------------
// mps_pkg: shared types and constants of the stream matcher
// Command and result records, configuration record, register indexes,
// engine states and the pattern byte lookup.
// ----------------------------------------------------------------------------
`default_nettype none

package mps_pkg;

  // configuration register indexes
  localparam logic [1:0] CFG_PATTERN_LENGTH = 2'd0;
  localparam logic [1:0] CFG_PATTERN_LOW    = 2'd1;
  localparam logic [1:0] CFG_PATTERN_HIGH   = 2'd2;

  // request kinds after classification
  typedef enum logic {
    CMD_RESTART = 1'b0,
    CMD_TEXT    = 1'b1
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [7:0]  text_byte;
  } cmd_t;

  typedef struct packed {
    logic        match_found;
    logic [31:0] match_start;
    logic [31:0] match_total;
  } result_t;

  typedef struct packed {
    logic [4:0]  pattern_length;
    logic [63:0] pattern_low;
    logic [63:0] pattern_high;
  } cfg_t;

  // engine sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MATCH,
    ST_FALL,
    ST_BUILD
  } eng_state_t;

  // pattern byte idx of the sixteen configured bytes
  function automatic logic [7:0] pat_byte(input cfg_t cfg, input logic [3:0] idx);
    logic [63:0] word;
    word = idx[3] ? cfg.pattern_high : cfg.pattern_low;
    return word[{idx[2:0], 3'b000} +: 8];
  endfunction

endpackage

`default_nettype wire

// File: design/mps_queue.sv
// ----------------------------------------------------------------------------
// mps_queue: small synchronous queue
// Decouples request classification from the engine and the engine from the
// result receiver. DEPTH must be a power of two.
// ----------------------------------------------------------------------------
`default_nettype none

module mps_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rdata,
  output logic                  empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [0:DEPTH-1];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      count <= count + CNT_W'(do_push) - CNT_W'(do_pop);
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

`default_nettype wire

// File: design/mps_engine.sv
// ----------------------------------------------------------------------------
// mps_engine: failure table builder and match sequencer
// Takes one command at a time from the command queue. A restart rebuilds
// the failure table one entry per step; a text byte follows one failure
// link per cycle until it can extend the match.
// ----------------------------------------------------------------------------
`default_nettype none

module mps_engine #(
  parameter int MAX_PATTERN    = 16,
  parameter int POSITION_WIDTH = 32
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire mps_pkg::cfg_t   cfg,
  input  wire logic            cmd_empty,
  input  wire mps_pkg::cmd_t   cmd,
  output logic                 cmd_pop,
  input  wire logic            res_full,
  output logic                 res_push,
  output mps_pkg::result_t     res
);

  localparam int LEN_W = $clog2(MAX_PATTERN + 1);
  localparam int PW    = POSITION_WIDTH;
  localparam logic [PW-1:0] POS_MAX = '1;
  localparam logic [31:0]   CNT_MAX = '1;

  mps_pkg::eng_state_t state, state_next;

  logic [LEN_W-1:0] tbl [0:MAX_PATTERN];
  logic [LEN_W-1:0] j, j_next;
  logic [LEN_W-1:0] k, k_next;
  logic [LEN_W-1:0] i, i_next;
  logic [7:0]       c, c_next;
  logic [PW-1:0]    pos, pos_next;
  logic [31:0]      count, count_next;

  logic             tbl_we;
  logic [LEN_W-1:0] tbl_waddr;
  logic [LEN_W-1:0] tbl_wdata;

  logic [LEN_W-1:0] m;
  logic [LEN_W-1:0] m_minus1;
  logic [LEN_W-1:0] rd_addr;
  logic [LEN_W-1:0] tbl_rd;
  logic [LEN_W-1:0] lnk;
  logic [7:0]       cur_c;
  logic             hit;
  logic             do_match;
  logic [LEN_W-1:0] jn;
  logic [LEN_W-1:0] kw;
  logic [PW-1:0]    start;

  // effective pattern length, clamped to 1..MAX_PATTERN
  always_comb begin
    if (cfg.pattern_length == '0) begin
      m = LEN_W'(1);
    end else if (int'(cfg.pattern_length) > MAX_PATTERN) begin
      m = LEN_W'(MAX_PATTERN);
    end else begin
      m = LEN_W'(cfg.pattern_length);
    end
    m_minus1 = m - LEN_W'(1);
  end

  // one table read and one pattern compare per cycle
  assign rd_addr = (state == mps_pkg::ST_BUILD) ? k : j;
  assign tbl_rd  = tbl[rd_addr];
  assign lnk     = (tbl_rd < rd_addr) ? tbl_rd : '0;
  assign cur_c   = (state == mps_pkg::ST_IDLE) ? cmd.text_byte : c;
  assign hit     = (mps_pkg::pat_byte(cfg, 4'(rd_addr)) == cur_c);
  assign jn      = j + LEN_W'(hit);
  assign kw      = k + LEN_W'(hit);
  assign start   = (pos >= PW'(m_minus1)) ? (pos - PW'(m_minus1)) : '0;

  // state register and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mps_pkg::ST_IDLE;
      j     <= '0;
      pos   <= '0;
      count <= '0;
    end else begin
      state <= state_next;
      j     <= j_next;
      pos   <= pos_next;
      count <= count_next;
    end
  end

  // build step registers
  always_ff @(posedge clk) begin
    k <= k_next;
    i <= i_next;
    c <= c_next;
  end

  // failure table, undefined until the first restart
  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl[tbl_waddr] <= tbl_wdata;
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    j_next     = j;
    k_next     = k;
    i_next     = i;
    c_next     = c;
    pos_next   = pos;
    count_next = count;
    cmd_pop    = 1'b0;
    res_push   = 1'b0;
    res        = '0;
    tbl_we     = 1'b0;
    tbl_waddr  = i;
    tbl_wdata  = kw;
    do_match   = 1'b0;

    unique case (state)
      mps_pkg::ST_IDLE: begin
        if (!cmd_empty && !res_full) begin
          cmd_pop = 1'b1;
          c_next  = cmd.text_byte;
          if (cmd.kind == mps_pkg::CMD_RESTART) begin
            tbl_we     = 1'b1;
            tbl_waddr  = LEN_W'(1);
            tbl_wdata  = '0;
            i_next     = LEN_W'(2);
            k_next     = '0;
            c_next     = mps_pkg::pat_byte(cfg, 4'd1);
            j_next     = '0;
            pos_next   = '0;
            count_next = '0;
            state_next = mps_pkg::ST_BUILD;
          end else begin
            do_match = 1'b1;
          end
        end
      end
      mps_pkg::ST_MATCH: begin
        do_match = 1'b1;
      end
      mps_pkg::ST_FALL: begin
        // fall back after a full occurrence so overlaps are found
        j_next     = lnk;
        state_next = mps_pkg::ST_IDLE;
      end
      mps_pkg::ST_BUILD: begin
        if (k != '0 && !hit) begin
          k_next = lnk;
        end else begin
          tbl_we = 1'b1;
          if (i == LEN_W'(MAX_PATTERN)) begin
            res_push   = 1'b1;
            state_next = mps_pkg::ST_IDLE;
          end else begin
            i_next = i + LEN_W'(1);
            k_next = kw;
            c_next = mps_pkg::pat_byte(cfg, 4'(i));
          end
        end
      end
      default: begin
        state_next = mps_pkg::ST_IDLE;
      end
    endcase

    // one match step on the current text byte
    if (do_match) begin
      if (j >= m) begin
        j_next     = lnk;
        state_next = mps_pkg::ST_MATCH;
      end else if (j != '0 && !hit) begin
        j_next     = lnk;
        state_next = mps_pkg::ST_MATCH;
      end else begin
        res_push = 1'b1;
        pos_next = (pos == POS_MAX) ? pos : pos + PW'(1);
        j_next   = jn;
        if (jn == m) begin
          count_next      = (count == CNT_MAX) ? count : count + 32'd1;
          res.match_found = 1'b1;
          res.match_start = 32'(start);
          res.match_total = count_next;
          state_next      = mps_pkg::ST_FALL;
        end else begin
          res.match_total = count;
          state_next      = mps_pkg::ST_IDLE;
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: design/morris_pratt_stream_matcher.sv
// ----------------------------------------------------------------------------
// morris_pratt_stream_matcher: streaming Morris-Pratt pattern matcher
// Input requests (restart or text byte) enter through push/full into a
// two-entry command queue; results leave through a two-entry result queue
// read with pop/empty. Configuration registers are written on the cfg port,
// which is always ready; the user is to write them only while the block is
// idle, and the block does not enforce this. A text byte is compared in the
// idle state, follows failure links in the match state until it can extend
// the match and, after a completed occurrence, falls back in the fall state.
// No new command is taken before the last is through; the limit is the
// single failure table read port, which serves one link per cycle. A restart
// writes the first table entry when taken, then the MAX_PATTERN-1 further
// entries in the build state, following failure links. When the receiver
// stalls, the result queue fills, the engine holds its next command and the
// command queue then raises full. Reset empties both queues, clears the
// match length, position and count and loads pattern_length 1 and zero
// pattern bytes; the failure table is undefined until the first restart
// request.
// ----------------------------------------------------------------------------
`default_nettype none

module morris_pratt_stream_matcher #(
  parameter int MAX_PATTERN    = 16,
  parameter int POSITION_WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic        action,
  input  wire logic [7:0]  text_byte,
  output logic             empty,
  input  wire logic        pop,
  output logic             match_found,
  output logic [31:0]      match_start,
  output logic [31:0]      match_total,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);

  localparam int CMD_W = $bits(mps_pkg::cmd_t);
  localparam int RES_W = $bits(mps_pkg::result_t);

  mps_pkg::cfg_t    cfg;
  mps_pkg::cmd_t    cmd_in;
  mps_pkg::cmd_t    cmd_head;
  mps_pkg::result_t res_in;
  mps_pkg::result_t res_head;

  logic [CMD_W-1:0] cmd_in_bits;
  logic [CMD_W-1:0] cmd_head_bits;
  logic [RES_W-1:0] res_in_bits;
  logic [RES_W-1:0] res_head_bits;
  logic             cmd_empty;
  logic             cmd_pop;
  logic             res_full;
  logic             res_push;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pattern_length <= 5'd1;
      cfg.pattern_low    <= '0;
      cfg.pattern_high   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        mps_pkg::CFG_PATTERN_LENGTH: cfg.pattern_length <= cfg_data[4:0];
        mps_pkg::CFG_PATTERN_LOW:    cfg.pattern_low    <= cfg_data;
        mps_pkg::CFG_PATTERN_HIGH:   cfg.pattern_high   <= cfg_data;
        default: ;
      endcase
    end
  end

  // classify incoming requests
  assign cmd_in.kind      = action ? mps_pkg::CMD_TEXT : mps_pkg::CMD_RESTART;
  assign cmd_in.text_byte = text_byte;
  assign cmd_in_bits      = cmd_in;
  assign cmd_head         = mps_pkg::cmd_t'(cmd_head_bits);

  mps_queue #(
    .WIDTH (CMD_W),
    .DEPTH (2)
  ) u_cmd_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (cmd_in_bits),
    .full  (full),
    .pop   (cmd_pop),
    .rdata (cmd_head_bits),
    .empty (cmd_empty)
  );

  mps_engine #(
    .MAX_PATTERN    (MAX_PATTERN),
    .POSITION_WIDTH (POSITION_WIDTH)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_empty (cmd_empty),
    .cmd       (cmd_head),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_in)
  );

  // result queue toward the receiver
  assign res_in_bits = res_in;

  mps_queue #(
    .WIDTH (RES_W),
    .DEPTH (2)
  ) u_res_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res_in_bits),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_head_bits),
    .empty (empty)
  );

  assign res_head    = mps_pkg::result_t'(res_head_bits);
  assign match_found = res_head.match_found;
  assign match_start = res_head.match_start;
  assign match_total = res_head.match_total;

endmodule

`default_nettype wire

// File: tb/sv/morris_pratt_stream_matcher_tb.sv
// ----------------------------------------------------------------------------
// morris_pratt_stream_matcher_tb: self-checking bench for the stream matcher
// Sends restart and text-byte requests through push/full with random gaps and
// pops results with random stalls. A border-table matcher inside the bench
// predicts every result, and each popped result is compared field by field.
// ----------------------------------------------------------------------------
module morris_pratt_stream_matcher_tb;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 1600;
  localparam int IDLE_PERCENT = 37;
  localparam int TAIL_CYCLES  = 20;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic        action = 1'b0;
  logic [7:0]  text_byte = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic        match_found;
  logic [31:0] match_start;
  logic [31:0] match_total;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = mps_pkg::CFG_PATTERN_LENGTH;
  logic [63:0] cfg_data = '0;

  bit steady = 1'b0;
  int error_count = 0;
  int cycle_count = 0;
  int random_sent = 0;

  // bench copy of the registers and matcher state
  logic [4:0]  len_reg = 5'd1;
  logic [63:0] low_reg = '0;
  logic [63:0] high_reg = '0;
  logic [4:0]  border_len [0:16];
  int unsigned matched_len = 0;
  logic [31:0] text_pos = '0;
  logic [31:0] occ_count = '0;
  mps_pkg::result_t predicted_matches [$];

  morris_pratt_stream_matcher dut (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .action      (action),
    .text_byte   (text_byte),
    .empty       (empty),
    .pop         (pop),
    .match_found (match_found),
    .match_start (match_start),
    .match_total (match_total),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // pattern byte idx, wrapping at sixteen
  function automatic logic [7:0] pattern_at(int unsigned idx);
    int unsigned k;
    logic [63:0] word;
    k = idx % 16;
    word = (k < 8) ? low_reg : high_reg;
    return word[(k % 8) * 8 +: 8];
  endfunction

  // pattern length clamped to 1..16
  function automatic int unsigned active_length();
    if (len_reg == 5'd0) return 1;
    if (len_reg > 5'd16) return 16;
    return len_reg;
  endfunction

  // border of the first j bytes, forced strictly below j
  function automatic int unsigned fall_back(int unsigned j);
    int unsigned t;
    t = (j <= 16) ? border_len[j] : 0;
    return (t < j) ? t : 0;
  endfunction

  // border table over all sixteen bytes, whatever the length
  function automatic void rebuild_borders();
    int unsigned i;
    int unsigned k;
    logic [7:0] c;
    border_len[0] = 5'd31;
    border_len[1] = 5'd0;
    for (i = 2; i <= 16; i++) begin
      c = pattern_at(i - 1);
      k = fall_back(i - 1);
      while (k > 0 && pattern_at(k) != c) k = fall_back(k);
      if (pattern_at(k) == c) k++;
      border_len[i] = k[4:0];
    end
  endfunction

  // advance the matcher by one request and form its result
  function automatic mps_pkg::result_t advance_matcher(mps_pkg::cmd_kind_t kind,
                                                       logic [7:0] c);
    mps_pkg::result_t r;
    int unsigned m;
    int unsigned j;
    r = '0;
    if (kind == mps_pkg::CMD_RESTART) begin
      rebuild_borders();
      matched_len = 0;
      text_pos = '0;
      occ_count = '0;
      return r;
    end
    m = active_length();
    j = matched_len;
    // a shorter pattern since restart: drop to a border below it
    while (j >= m) j = fall_back(j);
    while (j > 0 && pattern_at(j) != c) j = fall_back(j);
    if (pattern_at(j) == c) j++;
    if (j == m) begin
      r.match_found = 1'b1;
      r.match_start = (text_pos >= m - 1) ? text_pos - (m - 1) : 32'd0;
      if (occ_count != '1) occ_count++;
      j = fall_back(m);
    end
    matched_len = j;
    if (text_pos != '1) text_pos++;
    r.match_total = occ_count;
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      error_count++;
    end
  endfunction

  // one request, with a random gap ahead of it
  task automatic send_request(input mps_pkg::cmd_kind_t kind, input logic [7:0] data);
    while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    action <= kind;
    text_byte <= data;
    @(posedge clk);
    while (full) @(posedge clk);
    predicted_matches.insert(predicted_matches.size(), advance_matcher(kind, data));
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [63:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      mps_pkg::CFG_PATTERN_LENGTH: len_reg = value[4:0];
      mps_pkg::CFG_PATTERN_LOW:    low_reg = value;
      mps_pkg::CFG_PATTERN_HIGH:   high_reg = value;
      default: ;
    endcase
  endtask

  task automatic load_config(input logic [4:0] len, input logic [127:0] bytes);
    write_register(mps_pkg::CFG_PATTERN_LENGTH, {59'd0, len});
    write_register(mps_pkg::CFG_PATTERN_LOW, bytes[63:0]);
    write_register(mps_pkg::CFG_PATTERN_HIGH, bytes[127:64]);
    cfg_valid <= 1'b0;
  endtask

  // stop sending and let every predicted result come back
  task automatic wait_drained();
    push <= 1'b0;
    while (predicted_matches.size() != 0) @(posedge clk);
  endtask

  // result side: random stalls, compare each popped result
  always @(posedge clk) begin : result_checker
    mps_pkg::result_t want;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (predicted_matches.size() == 0) begin
          $error("result with no request pending: found %0d start %0d total %0d",
                 match_found, match_start, match_total);
          error_count++;
        end else begin
          want = predicted_matches.pop_front();
          check_field("match_found", want.match_found, match_found);
          check_field("match_start", want.match_start, match_start);
          check_field("match_total", want.match_total, match_total);
        end
      end
      pop <= steady || ($urandom_range(99) >= IDLE_PERCENT);
    end
  end

  // pattern 00 ff 00: overlapping hits and a fallback on mismatch
  task automatic test_overlapping_matches();
    wait_drained();
    load_config(5'd3, 128'h0000_FF00);
    send_request(mps_pkg::CMD_RESTART, 8'h00);
    send_request(mps_pkg::CMD_TEXT, 8'h00);
    send_request(mps_pkg::CMD_TEXT, 8'hFF);
    send_request(mps_pkg::CMD_TEXT, 8'h00);
    send_request(mps_pkg::CMD_TEXT, 8'hFF);
    send_request(mps_pkg::CMD_TEXT, 8'h00);
    send_request(mps_pkg::CMD_TEXT, 8'h00);
  endtask

  // zero length acts as one byte
  task automatic test_length_limits();
    wait_drained();
    load_config(5'd0, 128'hFF);
    send_request(mps_pkg::CMD_RESTART, 8'hFF);
    send_request(mps_pkg::CMD_TEXT, 8'hFF);
    send_request(mps_pkg::CMD_TEXT, 8'h7F);
    send_request(mps_pkg::CMD_TEXT, 8'hFF);
  endtask

  // length above sixteen, then a shorter pattern mid-match without restart
  task automatic test_config_without_restart();
    int k;
    logic [127:0] ramp;
    ramp = 128'h0F0E0D0C0B0A0908_0706050403020100;
    wait_drained();
    load_config(5'd31, ramp);
    send_request(mps_pkg::CMD_RESTART, 8'h00);
    for (k = 0; k < 10; k++) send_request(mps_pkg::CMD_TEXT, ramp[k * 8 +: 8]);
    wait_drained();
    load_config(5'd4, ramp);
    for (k = 0; k < 4; k++) send_request(mps_pkg::CMD_TEXT, ramp[k * 8 +: 8]);
  endtask

  // random patterns over small alphabets, text mostly built from the pattern
  task automatic test_random_streams();
    int phase;
    int span;
    int sent;
    int r;
    int k;
    int cut;
    int alpha_n;
    int plen;
    bit retune;
    logic [7:0] alphabet [4];
    logic [4:0] len;
    logic [127:0] pat_bits;
    phase = 0;
    while (random_sent < RANDOM_ITEMS) begin
      steady = (phase == 4 || phase == 5);
      alpha_n = $urandom_range(1, 4);
      r = $urandom_range(9);
      for (k = 0; k < 4; k++)
        alphabet[k] = (r == 0) ? ((k % 2) ? 8'hFF : 8'h00) : 8'($urandom_range(255));
      for (k = 0; k < 16; k++) pat_bits[k * 8 +: 8] = alphabet[$urandom_range(alpha_n - 1)];
      r = $urandom_range(9);
      case (r)
        0:       len = 5'd0;
        1:       len = 5'($urandom_range(17, 31));
        2:       len = 5'd16;
        3:       len = 5'd1;
        default: len = 5'($urandom_range(2, 8));
      endcase
      wait_drained();
      load_config(len, pat_bits);
      plen = active_length();
      send_request(mps_pkg::CMD_RESTART, 8'($urandom_range(255)));
      span = $urandom_range(30, 90);
      retune = ($urandom_range(3) == 0);
      sent = 0;
      while (sent < span) begin
        r = $urandom_range(99);
        if (r < 40) begin
          // whole pattern or a prefix of it
          cut = (r < 25) ? plen : $urandom_range(1, plen);
          for (k = 0; k < cut; k++) send_request(mps_pkg::CMD_TEXT, pat_bits[k * 8 +: 8]);
          sent += cut;
        end else if (r < 85) begin
          send_request(mps_pkg::CMD_TEXT, alphabet[$urandom_range(alpha_n - 1)]);
          sent++;
        end else if (r < 97) begin
          send_request(mps_pkg::CMD_TEXT, 8'($urandom_range(255)));
          sent++;
        end else begin
          send_request(mps_pkg::CMD_RESTART, 8'($urandom_range(255)));
          sent++;
        end
        // new length and one new byte while a match may be in progress
        if (retune && sent >= span / 2) begin
          retune = 1'b0;
          wait_drained();
          pat_bits[$urandom_range(15) * 8 +: 8] = alphabet[$urandom_range(alpha_n - 1)];
          load_config(5'($urandom_range(31)), pat_bits);
          plen = active_length();
        end
      end
      random_sent += sent + 1;
      phase++;
    end
    steady = 1'b0;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_overlapping_matches();
    test_length_limits();
    test_config_without_restart();
    test_random_streams();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("PASS morris_pratt_stream_matcher");
    end else begin
      $display("FAIL morris_pratt_stream_matcher");
    end
    $finish;
  end

  // run limit
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL morris_pratt_stream_matcher");
    $finish;
  end

endmodule

// File: files.f
design/mps_pkg.sv
design/mps_queue.sv
design/mps_engine.sv
design/morris_pratt_stream_matcher.sv
tb/sv/morris_pratt_stream_matcher_tb.sv
